/* rtl/core/tri2d_pkg.sv */
package tri2d_pkg;

    // Fixed formats of the ports.
    localparam int unsigned COORD_W = 16;
    localparam int unsigned RANGE_W = 15;
    localparam int unsigned ID_W    = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned NUM_REGS = 6;
    localparam int unsigned CFG_IDX_W = 3;

    // Intermediate widths: a,b,d,e fit 18 bits; c,f fit 35 bits.
    localparam int unsigned AB_W  = 18;
    localparam int unsigned CF_W  = 35;
    // Numerators fit 54 bits signed, denominator 36 bits signed.
    localparam int unsigned NUM_W = 54;
    localparam int unsigned DEN_W = 36;
    // Magnitudes.
    localparam int unsigned NMAG_W = NUM_W - 1;
    localparam int unsigned DMAG_W = DEN_W - 1;

    // Anchor identifiers.
    typedef enum logic [ID_W-1:0] {
        ID_A   = 2'd0,
        ID_B   = 2'd1,
        ID_C   = 2'd2,
        ID_UNK = 2'd3
    } t_sensor_id;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DEGN = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CY = 3'd5;

    // sqrt(3) in Q.24.
    localparam longint unsigned SQRT3_Q24 = 64'd29058990;

    // Queue entry: the three ranges to solve with.
    typedef struct packed {
        logic [RANGE_W-1:0] ra;
        logic [RANGE_W-1:0] rb;
        logic [RANGE_W-1:0] rc;
    } t_job;

endpackage

/* rtl/core/tri2d_stream_if.sv */
interface tri2d_stream_if #(
    parameter int unsigned W = 1
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
    // Passive view for observers that only watch the handshake.
    modport monitor (input valid, input data, input ready);
endinterface

/* rtl/core/tri2d_front.sv */
module tri2d_front
    import tri2d_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [ID_W-1:0]    i_sensor_id,
    input  logic [RANGE_W-1:0] i_distance,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output t_job               o_job
);

    localparam logic [RANGE_W-1:0] RANGE_RST =
        RANGE_W'((64'd1 << FRAC_BITS) & 64'h7FFF);

    logic [RANGE_W-1:0] r_ra, r_rb, r_rc;
    logic               fire;

    assign o_ready = i_job_ready;
    assign fire    = i_valid && i_job_ready;

    // Store the reporting anchor's range; unknown id keeps all.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ra <= RANGE_RST;
            r_rb <= RANGE_RST;
            r_rc <= RANGE_RST;
        end else if (fire) begin
            unique case (t_sensor_id'(i_sensor_id))
                ID_A:    r_ra <= i_distance;
                ID_B:    r_rb <= i_distance;
                ID_C:    r_rc <= i_distance;
                default: ;
            endcase
        end
    end

    // Forward the updated range set to the queue.
    always_comb begin
        o_job_valid = i_valid;
        o_job.ra = (t_sensor_id'(i_sensor_id) == ID_A) ? i_distance : r_ra;
        o_job.rb = (t_sensor_id'(i_sensor_id) == ID_B) ? i_distance : r_rb;
        o_job.rc = (t_sensor_id'(i_sensor_id) == ID_C) ? i_distance : r_rc;
    end

endmodule

/* rtl/core/tri2d_queue.sv */
module tri2d_queue
    import tri2d_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_job o_job
);

    // Two-entry queue in flip-flops.
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready)
        else $error("queue accepts while full");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("queue count out of range");
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> !pop)
        else $error("queue pops while empty");
`endif

endmodule

/* rtl/core/tri2d_back.sv */
module tri2d_back
    import tri2d_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_job_valid,
    output logic                      o_job_ready,
    input  t_job                      i_job,
    input  logic signed [COORD_W-1:0] i_xa,
    input  logic signed [COORD_W-1:0] i_ya,
    input  logic signed [COORD_W-1:0] i_xb,
    input  logic signed [COORD_W-1:0] i_yb,
    input  logic signed [COORD_W-1:0] i_xc,
    input  logic signed [COORD_W-1:0] i_yc,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [COORD_W-1:0] o_pos_x,
    output logic signed [COORD_W-1:0] o_pos_y,
    output logic [STAT_W-1:0]         o_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ1, S_SQ2, S_CF, S_M1, S_M2, S_M3, S_CHK,
        S_DIVX, S_DIVY, S_OUT
    } t_state;

    localparam int unsigned CNT_W = $clog2(NMAG_W + 1);

    t_state                    r_state;
    logic signed [AB_W-1:0]    r_a, r_b, r_d, r_e;
    logic signed [CF_W-1:0]    r_c, r_f;
    // Squares of the anchor coordinates (each up to 31 bits unsigned).
    logic signed [CF_W-1:0]    r_sq [6];
    logic signed [CF_W-1:0]    r_sr [3];
    logic signed [NUM_W-1:0]   r_p0, r_p1;
    logic signed [NUM_W-1:0]   r_xn, r_yn;
    logic signed [DEN_W-1:0]   r_den;
    logic [NMAG_W-1:0]         r_quo;
    logic [NMAG_W:0]           r_rem;
    logic [NMAG_W-1:0]         r_nmag;
    logic [DMAG_W-1:0]         r_dmag;
    logic                      r_neg;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [COORD_W-1:0] r_px;
    logic                      r_sat;
    logic signed [COORD_W-1:0] r_pos_x, r_pos_y;
    logic [STAT_W-1:0]         r_status;
    logic                      r_valid;

    logic [NMAG_W:0]           rem_sh;
    logic [NMAG_W:0]           rem_sub;
    logic [NMAG_W:0]           rnd;
    logic signed [NMAG_W+1:0]  sq_val;
    logic signed [COORD_W-1:0] clamped;
    logic                      clamp_sat;
    logic [NMAG_W-1:0]         ymag;
    logic                      yneg;

    assign o_job_ready = (r_state == S_IDLE);
    assign o_valid  = r_valid;
    assign o_pos_x  = r_pos_x;
    assign o_pos_y  = r_pos_y;
    assign o_status = r_status;

    // One restoring-division step per cycle.
    always_comb begin
        rem_sh  = {r_rem[NMAG_W-1:0], r_nmag[NMAG_W-1]};
        rem_sub = rem_sh - {{(NMAG_W+1-DMAG_W){1'b0}}, r_dmag};
        // Rounded quotient: remainder*2 >= divisor rounds the magnitude up.
        rnd     = {r_rem[NMAG_W-1:0], 1'b0};
        sq_val  = {2'b00, r_quo} +
                  {{(NMAG_W+1){1'b0}},
                   (rnd >= {{(NMAG_W+1-DMAG_W){1'b0}}, r_dmag})};
        if (r_neg) begin
            sq_val = -sq_val;
        end
        clamp_sat = 1'b0;
        if (sq_val > 32767) begin
            clamped = 16'sh7FFF;
            clamp_sat = 1'b1;
        end else if (sq_val < -32768) begin
            clamped = 16'sh8000;
            clamp_sat = 1'b1;
        end else begin
            clamped = COORD_W'(sq_val);
        end
        yneg = r_yn[NUM_W-1] != r_den[DEN_W-1];
        ymag = r_yn[NUM_W-1] ? NMAG_W'(-r_yn) : NMAG_W'(r_yn);
    end

    // Sequencer: squares, linear terms, cross products, two divisions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_a <= AB_W'(2 * (i_xb - i_xa));
                        r_b <= AB_W'(2 * (i_yb - i_ya));
                        r_d <= AB_W'(2 * (i_xc - i_xb));
                        r_e <= AB_W'(2 * (i_yc - i_yb));
                        r_sr[0] <= CF_W'(i_job.ra * i_job.ra);
                        r_sr[1] <= CF_W'(i_job.rb * i_job.rb);
                        r_sr[2] <= CF_W'(i_job.rc * i_job.rc);
                        r_state <= S_SQ1;
                    end
                end
                S_SQ1: begin
                    r_sq[0] <= CF_W'(i_xa * i_xa);
                    r_sq[1] <= CF_W'(i_ya * i_ya);
                    r_sq[2] <= CF_W'(i_xb * i_xb);
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_sq[3] <= CF_W'(i_yb * i_yb);
                    r_sq[4] <= CF_W'(i_xc * i_xc);
                    r_sq[5] <= CF_W'(i_yc * i_yc);
                    r_state <= S_CF;
                end
                S_CF: begin
                    r_c <= r_sr[0] - r_sr[1] - r_sq[0] + r_sq[2] - r_sq[1] + r_sq[3];
                    r_f <= r_sr[1] - r_sr[2] - r_sq[2] + r_sq[4] - r_sq[3] + r_sq[5];
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_p0 <= NUM_W'(r_a * r_e);
                    r_p1 <= NUM_W'(r_b * r_d);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_den <= DEN_W'(r_p0 - r_p1);
                    r_p0  <= NUM_W'(r_c * r_e);
                    r_p1  <= NUM_W'(r_f * r_b);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_xn <= r_p0 - r_p1;
                    r_yn <= NUM_W'(r_a * r_f) - NUM_W'(r_c * r_d);
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_den == '0) begin
                        r_pos_x  <= '0;
                        r_pos_y  <= '0;
                        r_status <= ST_DEGN;
                        r_valid  <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_neg  <= r_xn[NUM_W-1] != r_den[DEN_W-1];
                        r_nmag <= r_xn[NUM_W-1] ? NMAG_W'(-r_xn) : NMAG_W'(r_xn);
                        r_dmag <= r_den[DEN_W-1] ? DMAG_W'(-r_den) : DMAG_W'(r_den);
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_cnt  <= CNT_W'(NMAG_W);
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX, S_DIVY: begin
                    if (r_cnt != '0) begin
                        r_nmag <= {r_nmag[NMAG_W-2:0], 1'b0};
                        if (!rem_sub[NMAG_W]) begin
                            r_rem <= rem_sub;
                            r_quo <= {r_quo[NMAG_W-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_quo <= {r_quo[NMAG_W-2:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 1'b1;
                    end else if (r_state == S_DIVX) begin
                        r_px   <= clamped;
                        r_sat  <= clamp_sat;
                        r_neg  <= yneg;
                        r_nmag <= ymag;
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_cnt  <= CNT_W'(NMAG_W);
                        r_state <= S_DIVY;
                    end else begin
                        r_pos_x  <= r_px;
                        r_pos_y  <= clamped;
                        r_status <= (r_sat || clamp_sat) ? ST_SAT : ST_OK;
                        r_valid  <= 1'b1;
                        r_state  <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid && $stable(r_pos_x) && $stable(r_pos_y))
        else $error("result changed while stalled");
    a_degn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status == ST_DEGN |-> r_pos_x == '0 && r_pos_y == '0)
        else $error("degenerate result not zero");
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_OUT)
        else $error("result shown outside output state");
`endif

endmodule

/* rtl/core/trilateration_2d_position_top.sv */
// Three-anchor 2-D position solver. Each input item updates the range of anchor
// a, b or c (id 3 updates nothing) and yields one result item with the position
// in signed Q4.12 and a status (ok, saturated, degenerate). A sequencer in the
// back part takes the item and forms squares, linear terms and cross products in
// its states IDLE, SQ1, SQ2, CF, M1, M2, M3 and CHK, then runs two serial
// divisions of 53 steps plus a rounding step each, and holds the result until it
// is taken. The front part and a two-entry queue take new items meanwhile. Anchor
// coordinates are written through the config port while idle; the block does
// not enforce this, so the user must keep to it.
module trilateration_2d_position_top
    import tri2d_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COORD_W-1:0]    i_cfg_data,
    tri2d_stream_if.sink          in_ch,
    tri2d_stream_if.source        out_ch
);

    localparam int unsigned SH = 24 - FRAC_BITS;
    localparam logic [COORD_W-1:0] RST_AX = COORD_W'(64'd1 << FRAC_BITS);
    localparam logic [COORD_W-1:0] RST_AY =
        COORD_W'((SQRT3_Q24 + (64'd1 << (SH - 1))) >> SH);
    localparam logic [COORD_W-1:0] RST_BX = COORD_W'(64'd2 << FRAC_BITS);

    logic [COORD_W-1:0] r_regs [NUM_REGS];
    logic               job_valid, job_ready, q_valid, q_ready;
    t_job               job, q_job;

    // Anchor coordinate registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs[REG_AX] <= RST_AX;
            r_regs[REG_AY] <= RST_AY;
            r_regs[REG_BX] <= RST_BX;
            r_regs[REG_BY] <= '0;
            r_regs[REG_CX] <= '0;
            r_regs[REG_CY] <= '0;
        end else if (i_cfg_we && i_cfg_index <= REG_CY) begin
            r_regs[i_cfg_index] <= i_cfg_data;
        end
    end

    tri2d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_ch.valid),
        .o_ready     (in_ch.ready),
        .i_sensor_id (in_ch.data[ID_W+RANGE_W-1:RANGE_W]),
        .i_distance  (in_ch.data[RANGE_W-1:0]),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_job       (job)
    );

    tri2d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (job_valid),
        .o_ready (job_ready),
        .i_job   (job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    tri2d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .o_job_ready (q_ready),
        .i_job       (q_job),
        .i_xa        (signed'(r_regs[REG_AX])),
        .i_ya        (signed'(r_regs[REG_AY])),
        .i_xb        (signed'(r_regs[REG_BX])),
        .i_yb        (signed'(r_regs[REG_BY])),
        .i_xc        (signed'(r_regs[REG_CX])),
        .i_yc        (signed'(r_regs[REG_CY])),
        .o_valid     (out_ch.valid),
        .i_ready     (out_ch.ready),
        .o_pos_x     (out_ch.data[2*COORD_W+STAT_W-1:COORD_W+STAT_W]),
        .o_pos_y     (out_ch.data[COORD_W+STAT_W-1:STAT_W]),
        .o_status    (out_ch.data[STAT_W-1:0])
    );

endmodule

/* bench/tb_checker.sv */
`timescale 1ns / 1ps

// Watches the configuration port and both item channels, predicts each
// position result and compares it with what the block delivers.
module tb_checker
    import tri2d_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_W-1:0]   i_cfg_data,
    tri2d_stream_if.monitor      in_mon,
    tri2d_stream_if.monitor      out_mon,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [STAT_W-1:0]         status;
    } t_fix;

    logic signed [COORD_W-1:0] anchor_q [NUM_REGS];
    logic [RANGE_W-1:0]        rng_a, rng_b, rng_c;
    t_fix                      fix_q [$];

    assign o_pending = fix_q.size();

    // Quotient rounded to nearest, ties away from zero.
    function automatic longint div_nearest(longint n, longint d);
        longint nm, dm, q;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        q  = (nm + dm / 2) / dm;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    // Solves the circle-difference equations from the current anchors and ranges.
    function automatic t_fix solve_position(longint ra, longint rb, longint rc);
        longint xa, ya, xb, yb, xc, yc;
        longint a, b, c, d, e, f, den, px, py;
        t_fix   r;
        xa = anchor_q[REG_AX]; ya = anchor_q[REG_AY];
        xb = anchor_q[REG_BX]; yb = anchor_q[REG_BY];
        xc = anchor_q[REG_CX]; yc = anchor_q[REG_CY];
        a = 2 * (xb - xa);
        b = 2 * (yb - ya);
        c = ra * ra - rb * rb - xa * xa + xb * xb - ya * ya + yb * yb;
        d = 2 * (xc - xb);
        e = 2 * (yc - yb);
        f = rb * rb - rc * rc - xb * xb + xc * xc - yb * yb + yc * yc;
        den = a * e - b * d;
        r = '0;
        if (den == 0) begin
            r.status = ST_DEGN;
        end else begin
            px = div_nearest(c * e - f * b, den);
            py = div_nearest(a * f - c * d, den);
            r.status = ST_OK;
            if (px > 32767 || px < -32768 || py > 32767 || py < -32768) begin
                r.status = ST_SAT;
            end
            r.pos_x = (px > 32767) ? 16'sh7fff : (px < -32768) ? 16'sh8000 : px[15:0];
            r.pos_y = (py > 32767) ? 16'sh7fff : (py < -32768) ? 16'sh8000 : py[15:0];
        end
        return r;
    endfunction

    // Tracks configuration, stores ranges and checks results.
    always_ff @(posedge i_clk) begin
        logic [ID_W-1:0]    sid;
        logic [RANGE_W-1:0] rng_in;
        logic [RANGE_W-1:0] na, nb, nc;
        t_fix               got, want;
        if (!i_rst_n) begin
            anchor_q[REG_AX] <= 16'sd4096;
            anchor_q[REG_AY] <= 16'sd7094;
            anchor_q[REG_BX] <= 16'sd8192;
            anchor_q[REG_BY] <= '0;
            anchor_q[REG_CX] <= '0;
            anchor_q[REG_CY] <= '0;
            rng_a <= 15'd4096;
            rng_b <= 15'd4096;
            rng_c <= 15'd4096;
            o_errors <= 0;
            fix_q.delete();
        end else begin
            if (i_cfg_we && i_cfg_index < NUM_REGS) begin
                anchor_q[i_cfg_index] <= i_cfg_data;
            end
            if (in_mon.valid && in_mon.ready) begin
                {sid, rng_in} = in_mon.data;
                na = (sid == ID_A) ? rng_in : rng_a;
                nb = (sid == ID_B) ? rng_in : rng_b;
                nc = (sid == ID_C) ? rng_in : rng_c;
                rng_a <= na;
                rng_b <= nb;
                rng_c <= nc;
                fix_q.push_back(solve_position(na, nb, nc));
            end
            if (out_mon.valid && out_mon.ready) begin
                got = out_mon.data;
                if (fix_q.size() == 0) begin
                    $error("result item with none expected: %h", got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = fix_q.pop_front();
                    if (got.pos_x !== want.pos_x) begin
                        $error("pos_x expected %0d actual %0d", want.pos_x, got.pos_x);
                    end
                    if (got.pos_y !== want.pos_y) begin
                        $error("pos_y expected %0d actual %0d", want.pos_y, got.pos_y);
                    end
                    if (got.status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                    end
                    if (got !== want) begin
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import tri2d_pkg::*;

    localparam int IN_W     = ID_W + RANGE_W;
    localparam int OUT_W    = 2 * COORD_W + STAT_W;
    localparam int SETTLE   = 200;
    localparam int WD_LIMIT = 3000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;
    int                   errors;
    int                   pending;
    int                   quiet_cycles;
    bit                   idling;

    tri2d_stream_if #(.W(IN_W))  in_ch ();
    tri2d_stream_if #(.W(OUT_W)) out_ch ();

    trilateration_2d_position_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .in_ch      (in_ch.sink),
        .out_ch     (out_ch.source)
    );

    tb_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .in_mon     (in_ch.monitor),
        .out_mon    (out_ch.monitor),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side stalls in random bursts while idling is on.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (idling && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Ends the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WD_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(t_sensor_id sid, logic [RANGE_W-1:0] rng);
        in_ch.valid <= 1'b1;
        in_ch.data  <= {sid, rng};
        do @(negedge i_clk); while (!in_ch.ready);
        @(posedge i_clk);
        if (idling && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_anchors(logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                                 logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by,
                                 logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
        logic [COORD_W-1:0] vals [NUM_REGS];
        vals = '{ax, ay, bx, by, cx, cy};
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= vals[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Ranges mostly within a few metres, sometimes anywhere in the field.
    function automatic logic [RANGE_W-1:0] pick_range();
        if ($urandom_range(0, 3) == 0) return RANGE_W'($urandom_range(0, 32767));
        return RANGE_W'($urandom_range(1024, 16384));
    endfunction

    // Anchors mostly within about two metres of the origin.
    function automatic logic [COORD_W-1:0] pick_coord();
        int v;
        if ($urandom_range(0, 4) == 0) return COORD_W'($urandom);
        v = $urandom_range(0, 16384);
        return COORD_W'(v - 8192);
    endfunction

    task automatic random_items(int count);
        t_sensor_id sid;
        for (int n = 0; n < count; n++) begin
            sid = t_sensor_id'($urandom_range(0, 7) == 0 ? ID_UNK : $urandom_range(0, 2));
            send_item(sid, pick_range());
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        idling      = 1'b1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items on the reset anchors: every id, range extremes.
        send_item(ID_UNK, 15'd0);
        for (int s = 0; s < 4; s++) begin
            send_item(t_sensor_id'(s), 15'd0);
            send_item(t_sensor_id'(s), 15'h7fff);
        end
        send_item(ID_A, 15'd4096);
        send_item(ID_B, 15'd4096);
        send_item(ID_C, 15'd4096);
        send_item(ID_A, 15'h7fff);
        send_item(ID_B, 15'd0);
        send_item(ID_C, 15'h5555);
        send_item(ID_UNK, 15'h2aaa);
        random_items(60);
        drain();

        // Indexes past the last register must leave the anchors alone.
        cfg_we    <= 1'b1;
        cfg_index <= 3'd6;
        cfg_data  <= 16'hffff;
        @(posedge i_clk);
        cfg_index <= 3'd7;
        cfg_data  <= 16'h0000;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        send_item(ID_A, 15'd8192);
        send_item(ID_UNK, 15'd1);
        drain();

        // Collinear anchors give a degenerate status.
        write_anchors(16'd0, 16'd4096, 16'd4096, 16'd4096, 16'hf000, 16'd4096);
        send_item(ID_A, 15'd100);
        send_item(ID_UNK, 15'h7fff);
        random_items(10);
        drain();

        // Anchors at the corners of the coordinate range.
        write_anchors(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_item(ID_A, 15'h7fff);
        send_item(ID_B, 15'd0);
        random_items(40);
        drain();

        // Closely spaced anchors drive the results into saturation.
        write_anchors(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
        random_items(30);
        drain();

        // Random anchor layouts.
        for (int ph = 0; ph < 4; ph++) begin
            write_anchors(pick_coord(), pick_coord(), pick_coord(),
                          pick_coord(), pick_coord(), pick_coord());
            random_items(50);
            drain();
        end

        // Closing stretch runs without any idling.
        idling = 1'b0;
        write_anchors(16'd4096, 16'd7094, 16'd8192, 16'd0, 16'd0, 16'd0);
        random_items(40);
        drain();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
